[rtl/csrw_pkg.sv]
// shared types and constants for the cascaded shift register writer
package csrw_pkg;

  localparam int unsigned IDX_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned MAX_CHAIN  = 8;

  localparam logic [CNT_W-1:0]     CHAIN_LIMIT = CNT_W'(MAX_CHAIN);
  localparam logic [CNT_W-1:0]     COUNT_RESET = CNT_W'(MAX_CHAIN);

  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CASCADE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SHIFT
  } state_t;

  // controls from the sequencer to the serialiser
  typedef struct packed {
    logic              load;
    logic [BYTE_W-1:0] load_byte;
    logic              step;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  latch;
    logic              final_byte;
  } ser_ctl_t;

  typedef struct packed {
    logic free;
    logic byte_done;
  } ser_sts_t;

endpackage

[rtl/csrw_cache.sv]
// cached copy of every output register, one write and one read port
module csrw_cache (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [csrw_pkg::IDX_W-1:0]     wr_addr,
  input  logic [csrw_pkg::BYTE_W-1:0]    wr_data,
  input  logic [csrw_pkg::IDX_W-1:0]     rd_addr,
  output logic [csrw_pkg::BYTE_W-1:0]    rd_data
);
  import csrw_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_CHAIN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(MAX_CHAIN); i++) begin
        mem[i] <= '0;
      end
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data follows the address in the next cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> mem[$past(wr_addr)] == $past(wr_data))
    else $error("cache entry does not hold the byte just written");

endmodule

[rtl/csrw_serialiser.sv]
// bit shifter and output register, one bit per transfer, msb first
module csrw_serialiser (
  input  logic                           clk,
  input  logic                           rst,
  input  csrw_pkg::ser_ctl_t             ctl,
  output csrw_pkg::ser_sts_t             sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           serial_bit,
  output logic [csrw_pkg::IDX_W-1:0]     byte_slot,
  output logic [csrw_pkg::IDX_W-1:0]     latch_index,
  output logic                           last
);
  import csrw_pkg::*;

  logic [BYTE_W-1:0] sh;
  logic [2:0]        bit_cnt;

  assign sts.free      = !out_valid || !out_stall;
  assign sts.byte_done = (bit_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (ctl.load) begin
      sh      <= ctl.load_byte;
      bit_cnt <= '0;
    end else if (ctl.step) begin
      sh      <= {sh[BYTE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // the emitted bit comes from the old contents even on a reload
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      serial_bit  <= sh[BYTE_W-1];
      byte_slot   <= ctl.slot;
      latch_index <= ctl.latch;
      last        <= sts.byte_done && ctl.final_byte;
    end
  end

endmodule

[rtl/cascaded_shift_register_writer.sv]
// top level: sequencer, config registers, cache and serialiser
// first result bit passes ST_CHECK, ST_SHIFT and the serialiser output register
// a write shifts n bytes, n = 1..8, and takes no new input until it is done
// the serialiser sends one bit per cycle while out_stall does not hold it
// ignored or unchanged writes give no result
// reset: synchronous; cache cleared, parallel_mode 0, cascade_count 8
module cascaded_shift_register_writer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [csrw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csrw_pkg::CNT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [csrw_pkg::IDX_W-1:0]        reg_index,
  input  logic [csrw_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              force_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              serial_bit,
  output logic [csrw_pkg::IDX_W-1:0]        byte_slot,
  output logic [csrw_pkg::IDX_W-1:0]        latch_index,
  output logic                              last
);
  import csrw_pkg::*;

  state_t            state, state_next;
  logic              parallel_mode;
  logic [CNT_W-1:0]  cascade_count;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [BYTE_W-1:0] data, data_next;
  logic              force_q, force_next;
  logic [IDX_W-1:0]  slot, slot_next;
  logic [IDX_W-1:0]  lowest, lowest_next;

  logic [CNT_W-1:0]  eff_count;
  logic              in_range;
  logic              wr_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  ser_ctl_t          ctl;
  ser_sts_t          sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_mode <= 1'b0;
      cascade_count <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PARALLEL_MODE: parallel_mode <= cfg_data[0];
        CFG_CASCADE_COUNT: cascade_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_count = (cascade_count > CHAIN_LIMIT) ? CHAIN_LIMIT : cascade_count;
  assign in_range  = {1'b0, reg_index} < eff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    data    <= data_next;
    force_q <= force_next;
    slot    <= slot_next;
    lowest  <= lowest_next;
  end

  // the target entry is fetched on the input transfer, ready for the compare
  // next slot down is read while the current byte finishes shifting
  assign rd_addr = (state == ST_IDLE) ? reg_index : slot - IDX_W'(1);

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    data_next      = data;
    force_next     = force_q;
    slot_next      = slot;
    lowest_next    = lowest;
    in_stall       = 1'b1;
    wr_en          = 1'b0;
    ctl.load       = 1'b0;
    ctl.load_byte  = rd_data;
    ctl.step       = 1'b0;
    ctl.slot       = slot;
    ctl.latch      = idx;
    ctl.final_byte = (slot == lowest);
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        idx_next   = reg_index;
        data_next  = data_byte;
        force_next = force_req;
        if (in_valid && in_range) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rd_data != data || force_q) begin
          wr_en         = 1'b1;
          ctl.load      = 1'b1;
          ctl.load_byte = data;
          slot_next     = idx;
          lowest_next   = parallel_mode ? idx : '0;
          state_next    = ST_SHIFT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (sts.free) begin
          ctl.step = 1'b1;
          if (sts.byte_done) begin
            if (slot == lowest) begin
              state_next = ST_IDLE;
            end else begin
              ctl.load  = 1'b1;
              slot_next = slot - IDX_W'(1);
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  csrw_cache u_cache (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  csrw_serialiser u_ser (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .serial_bit  (serial_bit),
    .byte_slot   (byte_slot),
    .latch_index (latch_index),
    .last        (last)
  );

  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_slot <= latch_index)
    else $error("shifted slot above the target register");

  a_shift_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && sts.free) |=> out_valid)
    else $error("shift step did not produce a transfer");

  a_accept_checks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state != ST_SHIFT)
    else $error("shifting began without a cache compare");

  a_lowest_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> lowest <= slot)
    else $error("slot ran below the lowest register of the write");

endmodule
